// File: rtl/core/rgb_bin_color_gain_clamp_defines.svh
// Assertion macros for the pixel binning and colour gain block.
// Used by the top level; expects clk and rst in scope.
`ifndef RGB_BIN_COLOR_GAIN_CLAMP_DEFINES_SVH
`define RGB_BIN_COLOR_GAIN_CLAMP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBGC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbgc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RBGC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbgc: next-cycle check failed");

`endif

// File: rtl/core/rbgc_pkg.sv
// Shared constants, codes and types for the pixel binning and colour gain block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbgc_pkg;

  localparam int MAX_WIDTH     = 4096;
  localparam int MAX_BIN_SHIFT = 3;
  localparam int SAMPLE_BITS   = 16;

  localparam int IN_BITS       = 16;
  localparam int OUT_BITS      = 8;
  localparam int CLAMP_MAX     = 255;

  localparam int SUMS_DEPTH    = MAX_WIDTH / 2;
  localparam int IDX_BITS      = $clog2(SUMS_DEPTH);
  localparam int COL_BITS      = $clog2(MAX_WIDTH + 1);
  localparam int PH_BITS       = MAX_BIN_SHIFT;
  localparam int K_BITS        = $clog2(MAX_BIN_SHIFT + 1);
  localparam int SUM_BITS      = SAMPLE_BITS + 2 * MAX_BIN_SHIFT;

  localparam int COEF_BITS     = 16;
  localparam int OFF_BITS      = 16;
  localparam int BRIGHT_BITS   = 24;
  localparam int SCALE_FRAC    = 12;
  localparam int GAIN_FRAC     = 8;

  // Scaled-and-offset value, split into low and high halves for the gain multiply
  localparam int XP_BITS       = COEF_BITS + SUM_BITS;
  localparam int XO_BITS       = OFF_BITS + SCALE_FRAC + 2 * MAX_BIN_SHIFT;
  localparam int X_BITS        = ((XP_BITS > XO_BITS) ? XP_BITS : XO_BITS) + 2;
  localparam int LO_BITS       = 20;
  localparam int XH_BITS       = X_BITS - LO_BITS;
  localparam int Y_BITS        = X_BITS + COEF_BITS + 2;

  localparam int MA_0          = (SUM_BITS + 1 > LO_BITS + 1) ? SUM_BITS + 1 : LO_BITS + 1;
  localparam int MUL_A_BITS    = (MA_0 > XH_BITS) ? MA_0 : XH_BITS;
  localparam int MUL_B_BITS    = COEF_BITS + 1;
  localparam int MUL_P_BITS    = MUL_A_BITS + MUL_B_BITS;

  localparam int SH_BITS       = $clog2(SCALE_FRAC + GAIN_FRAC + 2 * MAX_BIN_SHIFT + 1);

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 48;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_BIN_SHIFT      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN           = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BRIGHTNESS     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_RED      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_GREEN    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_BLUE     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_OFFSETS = 3'd6;

  // Datapath arithmetic steps, one per cycle
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_MUL_SCALE = 3'd1;
  localparam logic [2:0] OP_ADD_OFF   = 3'd2;
  localparam logic [2:0] OP_MUL_LO    = 3'd3;
  localparam logic [2:0] OP_ACC_LO    = 3'd4;
  localparam logic [2:0] OP_MUL_HI    = 3'd5;
  localparam logic [2:0] OP_ACC_HI    = 3'd6;
  localparam logic [2:0] OP_CLAMP     = 3'd7;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [IN_BITS-1:0] red_in;
    logic [IN_BITS-1:0] green_in;
    logic [IN_BITS-1:0] blue_in;
    logic               row_last;
    logic               frame_first;
  } pix_in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] red_out;
    logic [OUT_BITS-1:0] green_out;
    logic [OUT_BITS-1:0] blue_out;
    logic                out_row_last;
  } pix_out_t;

  typedef struct packed {
    logic [1:0]             bin_shift;
    logic [COEF_BITS-1:0]   gain;
    logic [BRIGHT_BITS-1:0] brightness;
    logic [COEF_BITS-1:0]   scale_red;
    logic [COEF_BITS-1:0]   scale_green;
    logic [COEF_BITS-1:0]   scale_blue;
    logic [3*OFF_BITS-1:0]  channel_offsets;
  } cfg_t;

  typedef struct packed {
    logic       take;
    logic       update;
    logic [2:0] op;
    logic [1:0] chan;
    logic       load;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/rbgc_regs.sv
// Configuration register file for the pixel binning and colour gain block.
// Depends on rbgc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbgc_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rbgc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [rbgc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output rbgc_pkg::cfg_t                           cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bin_shift       <= 2'd0;
      cfg.gain            <= rbgc_pkg::COEF_BITS'(256);
      cfg.brightness      <= '0;
      cfg.scale_red       <= rbgc_pkg::COEF_BITS'(4096);
      cfg.scale_green     <= rbgc_pkg::COEF_BITS'(4096);
      cfg.scale_blue      <= rbgc_pkg::COEF_BITS'(4096);
      cfg.channel_offsets <= '0;
    end else if (cfg_valid) begin
      // writes beyond the list are dropped
      unique case (cfg_index)
        rbgc_pkg::REG_BIN_SHIFT:       cfg.bin_shift <= cfg_data[1:0];
        rbgc_pkg::REG_GAIN:            cfg.gain <= cfg_data[rbgc_pkg::COEF_BITS-1:0];
        rbgc_pkg::REG_BRIGHTNESS:      cfg.brightness <= cfg_data[rbgc_pkg::BRIGHT_BITS-1:0];
        rbgc_pkg::REG_SCALE_RED:       cfg.scale_red <= cfg_data[rbgc_pkg::COEF_BITS-1:0];
        rbgc_pkg::REG_SCALE_GREEN:     cfg.scale_green <= cfg_data[rbgc_pkg::COEF_BITS-1:0];
        rbgc_pkg::REG_SCALE_BLUE:      cfg.scale_blue <= cfg_data[rbgc_pkg::COEF_BITS-1:0];
        rbgc_pkg::REG_CHANNEL_OFFSETS: cfg.channel_offsets <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rbgc_ctrl.sv
// Sequencer for the pixel binning and colour gain block: handshakes and step order.
// Depends on rbgc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbgc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               pix_valid,
  output logic                    pix_ready,
  output logic                    res_valid,
  input  wire logic               res_ready,
  input  wire rbgc_pkg::dp_stat_t stat,
  output rbgc_pkg::dp_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;
  logic [2:0] op, op_next;
  logic [1:0] chan, chan_next;
  logic       res_valid_next;

  assign pix_ready = (state == S_IDLE);

  always_comb begin
    cmd.take   = pix_valid && pix_ready;
    cmd.update = (state == S_READ);
    cmd.op     = (state == S_CALC) ? op : rbgc_pkg::OP_NONE;
    cmd.chan   = chan;
    cmd.load   = (state == S_DONE) && (!res_valid || res_ready);
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    chan_next  = chan;
    unique case (state)
      S_IDLE: begin
        if (cmd.take) state_next = S_READ;
      end
      S_READ: begin
        // items that close no bin finish here
        if (stat.emit) begin
          state_next = S_CALC;
          op_next    = rbgc_pkg::OP_MUL_SCALE;
          chan_next  = rbgc_pkg::CH_RED;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CALC: begin
        unique case (op)
          rbgc_pkg::OP_MUL_SCALE: op_next = rbgc_pkg::OP_ADD_OFF;
          rbgc_pkg::OP_ADD_OFF:   op_next = rbgc_pkg::OP_MUL_LO;
          rbgc_pkg::OP_MUL_LO:    op_next = rbgc_pkg::OP_ACC_LO;
          rbgc_pkg::OP_ACC_LO:    op_next = rbgc_pkg::OP_MUL_HI;
          rbgc_pkg::OP_MUL_HI:    op_next = rbgc_pkg::OP_ACC_HI;
          rbgc_pkg::OP_ACC_HI:    op_next = rbgc_pkg::OP_CLAMP;
          rbgc_pkg::OP_CLAMP: begin
            op_next = rbgc_pkg::OP_MUL_SCALE;
            if (chan == rbgc_pkg::CH_BLUE) begin
              state_next = S_DONE;
            end else begin
              chan_next = chan + 2'd1;
            end
          end
          default: op_next = rbgc_pkg::OP_MUL_SCALE;
        endcase
      end
      S_DONE: begin
        // hold until the output register is free
        if (cmd.load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.load) res_valid_next = 1'b1;
    else if (res_ready)    res_valid_next = 1'b0;
    else                   res_valid_next = res_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= rbgc_pkg::OP_NONE;
      chan      <= rbgc_pkg::CH_RED;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      chan      <= chan_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rbgc_dp.sv
// Datapath: position counters, column sum store, shared multiplier and clamp.
// Depends on rbgc_pkg; driven by rbgc_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module rbgc_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rbgc_pkg::cfg_t    cfg,
  input  wire rbgc_pkg::dp_cmd_t cmd,
  input  wire rbgc_pkg::pix_in_t pix,
  output rbgc_pkg::dp_stat_t     stat,
  output rbgc_pkg::pix_out_t     res
);

  localparam int SB = rbgc_pkg::SUM_BITS;

  // position counters
  logic [rbgc_pkg::COL_BITS-1:0] column_count;
  logic [rbgc_pkg::PH_BITS-1:0]  row_phase;

  // decode of the incoming item
  logic [rbgc_pkg::K_BITS-1:0]   k_in;
  logic [rbgc_pkg::PH_BITS-1:0]  bmask_in, phase_in, col_lo;
  logic [rbgc_pkg::COL_BITS-1:0] col_in;
  logic [rbgc_pkg::IDX_BITS-1:0] idx_in;
  logic                          in_range_in, start_in, emit_in;

  // item held for the sum update and arithmetic
  logic [rbgc_pkg::K_BITS-1:0]   k_q;
  logic                          bin_q, in_range_q, start_q, emit_q, last_q;
  logic [rbgc_pkg::IDX_BITS-1:0] idx_q;
  logic [SB-1:0]                 px_r, px_g, px_b;
  logic [SB-1:0]                 sum_r, sum_g, sum_b;
  logic [SB-1:0]                 sum_r_next, sum_g_next, sum_b_next;

  // column sum store, blue:green:red per word
  logic [3*SB-1:0] sums_mem [rbgc_pkg::SUMS_DEPTH];
  logic [3*SB-1:0] rd_data;

  // arithmetic
  logic [rbgc_pkg::SH_BITS-1:0]           sh, sh2;
  logic [SB-1:0]                          sel_sum;
  logic [rbgc_pkg::COEF_BITS-1:0]         sel_scale;
  logic signed [rbgc_pkg::OFF_BITS-1:0]   sel_off;
  logic signed [rbgc_pkg::MUL_A_BITS-1:0] mul_a;
  logic signed [rbgc_pkg::MUL_B_BITS-1:0] mul_b;
  logic signed [rbgc_pkg::MUL_P_BITS-1:0] prod;
  logic signed [rbgc_pkg::X_BITS-1:0]     x_acc;
  logic signed [rbgc_pkg::Y_BITS-1:0]     y_acc;
  logic [rbgc_pkg::Y_BITS-1:0]            q;
  logic [rbgc_pkg::OUT_BITS-1:0]          clamped;
  logic [rbgc_pkg::OUT_BITS-1:0]          res_r, res_g, res_b;

  always_comb begin
    k_in = (cfg.bin_shift > rbgc_pkg::MAX_BIN_SHIFT) ?
           rbgc_pkg::K_BITS'(rbgc_pkg::MAX_BIN_SHIFT) : rbgc_pkg::K_BITS'(cfg.bin_shift);
    bmask_in    = rbgc_pkg::PH_BITS'((1 << k_in) - 1);
    col_in      = pix.frame_first ? '0 : column_count;
    phase_in    = (pix.frame_first ? '0 : row_phase) & bmask_in;
    col_lo      = col_in[rbgc_pkg::PH_BITS-1:0] & bmask_in;
    in_range_in = (col_in < rbgc_pkg::COL_BITS'(rbgc_pkg::MAX_WIDTH));
    start_in    = (phase_in == '0) && (col_lo == '0);
    // without binning the mask is empty, so every pixel in range closes a bin
    emit_in     = in_range_in && (phase_in == bmask_in) && (col_lo == bmask_in);
    idx_in      = rbgc_pkg::IDX_BITS'(col_in >> k_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_phase    <= '0;
    end else if (cmd.take) begin
      if (pix.row_last) begin
        column_count <= '0;
        row_phase    <= (phase_in + rbgc_pkg::PH_BITS'(1)) & bmask_in;
      end else begin
        if (in_range_in) column_count <= col_in + rbgc_pkg::COL_BITS'(1);
        else column_count <= col_in;
        row_phase <= pix.frame_first ? '0 : row_phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      k_q        <= k_in;
      bin_q      <= (k_in != '0);
      in_range_q <= in_range_in;
      start_q    <= start_in;
      emit_q     <= emit_in;
      last_q     <= pix.row_last;
      idx_q      <= idx_in;
      px_r       <= SB'(pix.red_in[rbgc_pkg::SAMPLE_BITS-1:0]);
      px_g       <= SB'(pix.green_in[rbgc_pkg::SAMPLE_BITS-1:0]);
      px_b       <= SB'(pix.blue_in[rbgc_pkg::SAMPLE_BITS-1:0]);
    end
  end

  assign stat.emit = emit_q;

  always_comb begin
    sum_r_next = start_q ? px_r : SB'(rd_data[SB-1:0] + px_r);
    sum_g_next = start_q ? px_g : SB'(rd_data[2*SB-1:SB] + px_g);
    sum_b_next = start_q ? px_b : SB'(rd_data[3*SB-1:2*SB] + px_b);
  end

  always_ff @(posedge clk) begin
    if (cmd.take) rd_data <= sums_mem[idx_in];
    if (cmd.update && in_range_q && bin_q) begin
      sums_mem[idx_q] <= {sum_b_next, sum_g_next, sum_r_next};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      sum_r <= sum_r_next;
      sum_g <= sum_g_next;
      sum_b <= sum_b_next;
    end
  end

  // unit = 2^(12+2k) for the offset and brightness terms, final drop 2^(20+2k)
  always_comb begin
    sh  = rbgc_pkg::SH_BITS'(rbgc_pkg::SCALE_FRAC + 2 * k_q);
    sh2 = rbgc_pkg::SH_BITS'(rbgc_pkg::SCALE_FRAC + rbgc_pkg::GAIN_FRAC + 2 * k_q);
  end

  always_comb begin
    unique case (cmd.chan)
      rbgc_pkg::CH_GREEN: begin
        sel_sum   = sum_g;
        sel_scale = cfg.scale_green;
        sel_off   = $signed(cfg.channel_offsets[2*rbgc_pkg::OFF_BITS-1:rbgc_pkg::OFF_BITS]);
      end
      rbgc_pkg::CH_BLUE: begin
        sel_sum   = sum_b;
        sel_scale = cfg.scale_blue;
        sel_off   = $signed(cfg.channel_offsets[3*rbgc_pkg::OFF_BITS-1:2*rbgc_pkg::OFF_BITS]);
      end
      default: begin
        sel_sum   = sum_r;
        sel_scale = cfg.scale_red;
        sel_off   = $signed(cfg.channel_offsets[rbgc_pkg::OFF_BITS-1:0]);
      end
    endcase
  end

  // one shared signed multiplier; operands chosen by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      rbgc_pkg::OP_MUL_SCALE: begin
        mul_a = rbgc_pkg::MUL_A_BITS'(sel_sum);
        mul_b = rbgc_pkg::MUL_B_BITS'(sel_scale);
      end
      rbgc_pkg::OP_MUL_LO: begin
        mul_a = rbgc_pkg::MUL_A_BITS'(x_acc[rbgc_pkg::LO_BITS-1:0]);
        mul_b = rbgc_pkg::MUL_B_BITS'(cfg.gain);
      end
      rbgc_pkg::OP_MUL_HI: begin
        mul_a = rbgc_pkg::MUL_A_BITS'($signed(x_acc[rbgc_pkg::X_BITS-1:rbgc_pkg::LO_BITS]));
        mul_b = rbgc_pkg::MUL_B_BITS'(cfg.gain);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    q = $unsigned(y_acc) >> sh2;
    priority if (y_acc[rbgc_pkg::Y_BITS-1]) clamped = '0;
    else if (q > rbgc_pkg::Y_BITS'(rbgc_pkg::CLAMP_MAX))
      clamped = rbgc_pkg::OUT_BITS'(rbgc_pkg::CLAMP_MAX);
    else clamped = q[rbgc_pkg::OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rbgc_pkg::OP_MUL_SCALE, rbgc_pkg::OP_MUL_LO, rbgc_pkg::OP_MUL_HI: begin
        prod <= mul_a * mul_b;
      end
      rbgc_pkg::OP_ADD_OFF: begin
        x_acc <= rbgc_pkg::X_BITS'(prod) + (rbgc_pkg::X_BITS'(sel_off) <<< sh);
      end
      rbgc_pkg::OP_ACC_LO: begin
        y_acc <= rbgc_pkg::Y_BITS'(prod)
               + (rbgc_pkg::Y_BITS'($signed(cfg.brightness)) <<< sh);
      end
      rbgc_pkg::OP_ACC_HI: begin
        y_acc <= y_acc + (rbgc_pkg::Y_BITS'(prod) <<< rbgc_pkg::LO_BITS);
      end
      rbgc_pkg::OP_CLAMP: begin
        unique case (cmd.chan)
          rbgc_pkg::CH_GREEN: res_g <= clamped;
          rbgc_pkg::CH_BLUE:  res_b <= clamped;
          default:            res_r <= clamped;
        endcase
      end
      default: begin
      end
    endcase
  end

  // output register, loaded once the previous item has gone
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res.red_out      <= res_r;
      res.green_out    <= res_g;
      res.blue_out     <= res_b;
      res.out_row_last <= last_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rgb_bin_color_gain_clamp.sv
// Top level of the RGB pixel binning, colour scale, gain and clamp block.
// Depends on rbgc_pkg, rbgc_regs, rbgc_ctrl, rbgc_dp and the assertion header.
//
//  channel  | signals                               | moves
//  ---------+---------------------------------------+----------------------------
//  pixel in | pix_valid, pix_ready, pix             | one source pixel per item
//  result   | res_valid, res_ready, res             | one display pixel per bin
//  config   | cfg_valid, cfg_ready, cfg_index/data  | one register write
//
// A pixel that closes no bin is accepted, then makes its column sum store update. A
// pixel that closes a bin does the same, then 7 steps per channel on the one shared
// 23x17 multiplier, then loads the output register once it is free. The output
// register holds a result while the next pixel is taken. A stalled result holds the
// next bin-closing pixel and closes the input behind it. Reset clears the counters
// and the sequencer; the column sum store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_bin_color_gain_clamp_defines.svh"

module rgb_bin_color_gain_clamp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                pix_valid,
  output logic                                     pix_ready,
  input  wire rbgc_pkg::pix_in_t                   pix,
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output rbgc_pkg::pix_out_t                       res,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rbgc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [rbgc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  rbgc_pkg::cfg_t     cfg;
  rbgc_pkg::dp_cmd_t  cmd;
  rbgc_pkg::dp_stat_t stat;

  rbgc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rbgc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rbgc_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .cmd  (cmd),
    .pix  (pix),
    .stat (stat),
    .res  (res)
  );

  // a taken pixel blocks the input until its sum update is done
  `RBGC_ASSERT_NEXT(a_busy_after_take, pix_valid && pix_ready, !pix_ready)
  // never overwrite a result that is still waiting
  `RBGC_ASSERT_IMP(a_load_when_free, cmd.load, !res_valid || res_ready)
  `RBGC_ASSERT_NEXT(a_load_shows_result, cmd.load, res_valid)
  // arithmetic steps run only while the input is closed
  `RBGC_ASSERT_IMP(a_calc_input_closed, cmd.op != rbgc_pkg::OP_NONE, !pix_ready)

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for rgb_bin_color_gain_clamp: raster frames and register writes in,
// every binned display pixel predicted and compared. Depends on rbgc_pkg and the RTL only.

module tb_top;

  localparam int SETTLE_CYCLES  = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 140;
  localparam int REPORT_LIMIT   = 10;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CYCLIC} rx_mode_t;

  // Tracks registers, column/row position and the column sums; queues due display pixels
  class bin_colour_tracker_t;
    logic [1:0]                    bin_shift = 2'd0;
    logic [15:0]                   gain = 16'd256;
    logic [23:0]                   brightness = '0;
    logic [15:0]                   scale [3] = '{16'd4096, 16'd4096, 16'd4096};
    logic [47:0]                   offsets = '0;
    int unsigned                   col_count = 0;
    int unsigned                   row_phase = 0;
    logic [rbgc_pkg::SUM_BITS-1:0] sums [3][rbgc_pkg::SUMS_DEPTH];
    bit                            written [rbgc_pkg::SUMS_DEPTH];
    rbgc_pkg::pix_out_t            due_pixels [$];
    int                            faults = 0;
    int                            checked = 0;
    int                            taken = 0;
    int                            dropped = 0;

    function int unsigned bin_log2();
      return (bin_shift > rbgc_pkg::MAX_BIN_SHIFT) ? rbgc_pkg::MAX_BIN_SHIFT : bin_shift;
    endfunction

    function void note_setting(logic [rbgc_pkg::CFG_INDEX_BITS-1:0] idx,
                               logic [rbgc_pkg::CFG_DATA_BITS-1:0] d);
      case (idx)
        rbgc_pkg::REG_BIN_SHIFT:       bin_shift = d[1:0];
        rbgc_pkg::REG_GAIN:            gain = d[15:0];
        rbgc_pkg::REG_BRIGHTNESS:      brightness = d[23:0];
        rbgc_pkg::REG_SCALE_RED:       scale[rbgc_pkg::CH_RED] = d[15:0];
        rbgc_pkg::REG_SCALE_GREEN:     scale[rbgc_pkg::CH_GREEN] = d[15:0];
        rbgc_pkg::REG_SCALE_BLUE:      scale[rbgc_pkg::CH_BLUE] = d[15:0];
        rbgc_pkg::REG_CHANNEL_OFFSETS: offsets = d[47:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] display_level(logic [rbgc_pkg::SUM_BITS-1:0] sum, int unsigned k,
                                       logic [15:0] sc, logic [15:0] off);
      longint unit, x, y;
      unit = longint'(1) << (rbgc_pkg::SCALE_FRAC + 2 * k);
      x = longint'(sc) * longint'(sum) + longint'($signed(off)) * unit;
      y = x * longint'(gain) + longint'($signed(brightness)) * unit;
      if (y < 0) return 8'd0;
      y = y >> (rbgc_pkg::SCALE_FRAC + rbgc_pkg::GAIN_FRAC + 2 * k);
      return (y > rbgc_pkg::CLAMP_MAX) ? 8'(rbgc_pkg::CLAMP_MAX) : y[7:0];
    endfunction

    // True when the pixel would accumulate onto a sum entry never written since reset
    function bit hits_unwritten_sum(rbgc_pkg::pix_in_t p);
      int unsigned k, bmask, phase;
      k = bin_log2();
      bmask = (1 << k) - 1;
      phase = row_phase & bmask;
      if (p.frame_first || k == 0 || col_count >= rbgc_pkg::MAX_WIDTH) return 1'b0;
      if (phase == 0 && (col_count & bmask) == 0) return 1'b0;
      return !written[(col_count >> k) % rbgc_pkg::SUMS_DEPTH];
    endfunction

    function void take_pixel(rbgc_pkg::pix_in_t p);
      int unsigned k, bmask, col, phase, idx;
      logic [rbgc_pkg::SUM_BITS-1:0] s [3];
      bit emit, open;
      rbgc_pkg::pix_out_t r;
      k = bin_log2();
      bmask = (1 << k) - 1;
      emit = 1'b0;
      s[rbgc_pkg::CH_RED] = p.red_in;
      s[rbgc_pkg::CH_GREEN] = p.green_in;
      s[rbgc_pkg::CH_BLUE] = p.blue_in;
      taken++;
      if (p.frame_first) begin
        col_count = 0;
        row_phase = 0;
      end
      col = col_count;
      phase = row_phase & bmask;
      if (col < rbgc_pkg::MAX_WIDTH) begin
        if (k == 0) begin
          emit = 1'b1;
        end else begin
          idx = (col >> k) % rbgc_pkg::SUMS_DEPTH;
          open = (phase == 0) && ((col & bmask) == 0);
          for (int c = 0; c < 3; c++) begin
            if (!open) s[c] = sums[c][idx] + s[c];
            sums[c][idx] = s[c];
          end
          written[idx] = 1'b1;
          emit = (phase == bmask) && ((col & bmask) == bmask);
        end
        col_count = col + 1;
      end else begin
        dropped++;
      end
      if (p.row_last) begin
        col_count = 0;
        row_phase = (phase + 1) & bmask;
      end
      if (emit) begin
        r.red_out = display_level(s[rbgc_pkg::CH_RED], k, scale[rbgc_pkg::CH_RED],
                                  offsets[15:0]);
        r.green_out = display_level(s[rbgc_pkg::CH_GREEN], k, scale[rbgc_pkg::CH_GREEN],
                                    offsets[31:16]);
        r.blue_out = display_level(s[rbgc_pkg::CH_BLUE], k, scale[rbgc_pkg::CH_BLUE],
                                   offsets[47:32]);
        r.out_row_last = p.row_last;
        due_pixels.push_back(r);
      end
    endfunction

    function void note_fault(string msg);
      faults++;
      if (faults <= REPORT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void check_display_pixel(rbgc_pkg::pix_out_t got);
      rbgc_pkg::pix_out_t want;
      if (due_pixels.size() == 0) begin
        note_fault($sformatf("display pixel %p arrived with none due", got));
        return;
      end
      want = due_pixels.pop_front();
      checked++;
      if (got.red_out !== want.red_out)
        note_fault($sformatf("pixel %0d red_out: expected %0d, got %0d",
                             checked, want.red_out, got.red_out));
      if (got.green_out !== want.green_out)
        note_fault($sformatf("pixel %0d green_out: expected %0d, got %0d",
                             checked, want.green_out, got.green_out));
      if (got.blue_out !== want.blue_out)
        note_fault($sformatf("pixel %0d blue_out: expected %0d, got %0d",
                             checked, want.blue_out, got.blue_out));
      if (got.out_row_last !== want.out_row_last)
        note_fault($sformatf("pixel %0d out_row_last: expected %0b, got %0b",
                             checked, want.out_row_last, got.out_row_last));
    endfunction
  endclass

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                pix_valid = 1'b0;
  logic                                pix_ready;
  rbgc_pkg::pix_in_t                   pix = '0;
  logic                                res_valid;
  logic                                res_ready = 1'b0;
  rbgc_pkg::pix_out_t                  res;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [rbgc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [rbgc_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  bin_colour_tracker_t board = new();

  int       burst_left = 0;
  bit       gaps_on = 1'b1;
  int       settings_used = 0;
  rx_mode_t ready_mode = RX_OPEN;
  int       mode_left = 0;
  int       ready_tick = 0;
  int       quiet_cycles = 0;

  rgb_bin_color_gain_clamp dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 255));
      1: return 16'($urandom_range(0, 4095));
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_coef(int unsigned low_max);
    return $urandom_range(0, 1) ? 16'($urandom_range(0, low_max)) : 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_offset();
    return $urandom_range(0, 1) ? 16'($urandom_range(0, 1024) - 512) : 16'($urandom);
  endfunction

  function automatic rbgc_pkg::pix_in_t px(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                           logic last, logic first);
    rbgc_pkg::pix_in_t p;
    p.red_in = r;
    p.green_in = g;
    p.blue_in = b;
    p.row_last = last;
    p.frame_first = first;
    return p;
  endfunction

  // Hold the item until taken; bursts of random length, random gaps between them if gaps_on
  task automatic send_pixel(rbgc_pkg::pix_in_t p);
    if (burst_left == 0) begin
      if (gaps_on) begin
        pix_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    // restart the frame rather than accumulate onto a never-written sum
    if (board.hits_unwritten_sum(p)) p.frame_first = 1'b1;
    pix <= p;
    pix_valid <= 1'b1;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    board.take_pixel(p);
  endtask

  task automatic send_frame(int cols, int rows, bit mark_start, int noise_pct);
    rbgc_pkg::pix_in_t p;
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < cols; x++) begin
        p = px(pick_sample(), pick_sample(), pick_sample(), x == cols - 1,
               mark_start && x == 0 && y == 0);
        if ($urandom_range(1, 100) <= noise_pct) begin
          p.row_last = 1'($urandom_range(0, 1));
          p.frame_first = 1'($urandom_range(0, 1));
        end
        send_pixel(p);
      end
    end
  endtask

  task automatic send_noise(int n);
    repeat (n)
      send_pixel(px(pick_sample(), pick_sample(), pick_sample(), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 3) == 0));
  endtask

  task automatic wait_idle();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (board.due_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [rbgc_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [rbgc_pkg::CFG_DATA_BITS-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.note_setting(idx, value);
  endtask

  task automatic apply_settings(logic [1:0] bs, logic [15:0] g, logic [23:0] br,
                                logic [15:0] sr, logic [15:0] sg, logic [15:0] sbl,
                                logic [47:0] off);
    wait_idle();
    write_reg(rbgc_pkg::REG_BIN_SHIFT, 48'(bs));
    write_reg(rbgc_pkg::REG_GAIN, 48'(g));
    write_reg(rbgc_pkg::REG_BRIGHTNESS, 48'(br));
    write_reg(rbgc_pkg::REG_SCALE_RED, 48'(sr));
    write_reg(rbgc_pkg::REG_SCALE_GREEN, 48'(sg));
    write_reg(rbgc_pkg::REG_SCALE_BLUE, 48'(sbl));
    write_reg(rbgc_pkg::REG_CHANNEL_OFFSETS, off);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_settings(int ph);
    logic [15:0] g, sr, sg, sbl;
    logic [23:0] br;
    logic [47:0] off;
    case (ph)
      0: begin
        g = 16'd0; br = 24'h7FFFFF; sr = '0; sg = '0; sbl = '0;
        off = 48'h7FFF_7FFF_7FFF;
      end
      1: begin
        g = 16'hFFFF; br = 24'h800000; sr = 16'hFFFF; sg = 16'hFFFF; sbl = 16'hFFFF;
        off = 48'h8000_8000_8000;
      end
      2: begin
        g = 16'd256; br = '0; sr = 16'd4096; sg = 16'd4096; sbl = 16'd4096;
        off = {16'h0000, 16'h7FFF, 16'h8000};
      end
      default: begin
        g = pick_coef(1023);
        br = $urandom_range(0, 1) ? 24'($urandom_range(0, 1 << 17) - (1 << 16))
                                  : 24'($urandom);
        sr = pick_coef(255);
        sg = pick_coef(255);
        sbl = pick_coef(255);
        off = {pick_offset(), pick_offset(), pick_offset()};
      end
    endcase
    apply_settings(2'(ph % 4), g, br, sr, sg, sbl, off);
  endtask

  initial begin
    int base, cols, rows, k;
    bit fresh;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings, no binning: sample extremes, clamp edge, both flags
    send_pixel(px(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1));
    send_pixel(px(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    send_pixel(px(16'h00FF, 16'h0100, 16'h00FE, 1'b0, 1'b0));
    send_pixel(px(16'hAAAA, 16'h5555, 16'h0001, 1'b1, 1'b0));
    send_pixel(px(16'h5555, 16'hAAAA, 16'h8000, 1'b1, 1'b1));

    // 2x2 bins on an odd width: the leftover column drops and no row end comes out
    apply_settings(2'd1, 16'd256, 24'd0, 16'd4096, 16'd4096, 16'd4096,
                   {16'h0001, 16'hFFFF, 16'h0000});
    send_frame(5, 2, 1'b1, 0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      gaps_on = (ph % 3 != 2);
      random_settings(ph);
      k = ph % 4;
      base = board.taken;
      // half the time carry on mid-frame under the new bin size
      fresh = $urandom_range(0, 1);
      while (board.taken - base < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) begin
          send_noise($urandom_range(5, 20));
        end else begin
          cols = (1 << k) * $urandom_range(1, (k == 3) ? 2 : 6);
          rows = (1 << k) * $urandom_range(1, (k >= 2) ? 1 : 3);
          if ($urandom_range(0, 3) == 0) cols += $urandom_range(0, (1 << k) - 1);
          if ($urandom_range(0, 3) == 0) rows += $urandom_range(0, (1 << k) - 1);
          send_frame(cols, rows, fresh, 4);
          fresh = 1'b1;
        end
      end
    end

    wait_idle();
    $display("summary: %0d pixels taken, %0d past the row limit, %0d display pixels checked",
             board.taken, board.dropped, board.checked);
    $display("summary: %0d register settings over bin sizes 1 to 8, %0d mismatches",
             settings_used, board.faults);
    if (board.faults == 0 && board.due_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: check each taken item, stall in modes that change every so often
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) board.check_display_pixel(res);
      if (mode_left == 0) begin
        ready_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      ready_tick++;
      case (ready_mode)
        RX_OPEN:   res_ready <= 1'b1;
        RX_COIN:   res_ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
        default:   res_ready <= (ready_tick % 7 < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_valid && pix_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d display pixels due",
               quiet_cycles, board.due_pixels.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
